// ===== src/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcd_pkg: shared definitions for the directed cycle detector
// Field widths, bus widths and the queue entry that passes from the front
// end to the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

    // Fixed field widths of the stream items and the configuration register.
    localparam int ROW_W      = 16;
    localparam int IDX_W      = 4;
    localparam int VCOUNT_W   = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    localparam int DEFAULT_MAX_VERTICES = 16;

    // Depth of the queue between the front end and the search engine.
    localparam int QUEUE_DEPTH = 2;

    // One classified row transaction, as queued for the search engine.
    typedef struct packed {
        logic             store;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
        logic             last;
    } dcd_item_t;

endpackage

`default_nettype wire

// ===== src/dcd_front.sv =====
// ----------------------------------------------------------------------------
// dcd_front: input stage of the directed cycle detector
// Accepts row transactions, decides whether the row is kept, and buffers
// them in a short queue for the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_front #(
    parameter int MAX_VERTICES = dcd_pkg::DEFAULT_MAX_VERTICES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [dcd_pkg::IDX_W-1:0]   row_index,
    input  wire logic [dcd_pkg::ROW_W-1:0]   row_bits,
    input  wire logic                        last_row,
    output logic                             q_valid,
    input  wire logic                        q_ready,
    output dcd_pkg::dcd_item_t               q_item
);
    import dcd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dcd_item_t         queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    dcd_item_t         new_item;
    logic              push;
    logic              pop;

    // Rows at or above the store depth are dropped; their last flag still counts.
    always_comb
    begin
        new_item.store     = (32'(row_index) < 32'(MAX_VERTICES));
        new_item.row_index = row_index;
        new_item.row_bits  = row_bits;
        new_item.last      = last_row;
    end

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_full_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_ready && pop) |=> s_ready)
        else $error("queue stays full after a pop");

endmodule

`default_nettype wire

// ===== src/dcd_back.sv =====
// ----------------------------------------------------------------------------
// dcd_back: search engine of the directed cycle detector
// Holds the adjacency rows and runs a stack-based depth-first search with
// per-vertex marks, one push or pop per cycle, then registers the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_back #(
    parameter int MAX_VERTICES = dcd_pkg::DEFAULT_MAX_VERTICES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [dcd_pkg::VCOUNT_W-1:0]  vertex_count,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire dcd_pkg::dcd_item_t            q_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               has_cycle
);
    import dcd_pkg::*;

    // Vertices that can take part in a search: bounded by the row width too.
    localparam int EFF_V   = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
    localparam int VIDX_W  = $clog2(EFF_V);
    localparam int DEPTH_W = $clog2(EFF_V + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MARK_NEW  = 2'd0,
        MARK_PATH = 2'd1,
        MARK_DONE = 2'd2
    } mark_t;

    logic [EFF_V-1:0]     rows_mem  [EFF_V];
    logic [VIDX_W-1:0]    stack_mem [EFF_V];

    state_t               state_reg, state_next;
    mark_t                marks_reg [EFF_V];
    mark_t                marks_next [EFF_V];
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [VCOUNT_W-1:0]  n_reg, n_next;
    logic                 result_reg, result_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 has_cycle_reg, has_cycle_next;

    logic [VCOUNT_W-1:0]  n_active;
    logic [EFF_V-1:0]     vmask;
    logic [DEPTH_W-1:0]   depth_m1;
    logic [VIDX_W-1:0]    top_v;
    logic [EFF_V-1:0]     edges;
    logic [EFF_V-1:0]     open_bits;
    logic [EFF_V-1:0]     new_bits;
    logic [EFF_V-1:0]     cand;
    logic                 found;
    logic [VIDX_W-1:0]    sel_v;
    logic                 q_fire;
    logic                 push;

    assign n_active = (vertex_count > VCOUNT_W'(EFF_V)) ? VCOUNT_W'(EFF_V) : vertex_count;
    assign depth_m1 = depth_reg - 1'b1;
    assign top_v    = stack_mem[depth_m1[VIDX_W-1:0]];
    assign edges    = rows_mem[top_v] & vmask;
    assign q_ready  = (state_reg == ST_IDLE);
    assign q_fire   = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign has_cycle = has_cycle_reg;

    always_comb
    begin
        for (int v = 0; v < EFF_V; v++)
        begin
            vmask[v]     = (VCOUNT_W'(v) < n_reg);
            open_bits[v] = edges[v] && (marks_reg[v] != MARK_DONE);
            new_bits[v]  = vmask[v] && (marks_reg[v] == MARK_NEW);
        end
    end

    // With an empty stack, look for the next root; otherwise for the first
    // edge of the top vertex that does not lead to a finished vertex.
    assign cand  = (depth_reg == '0) ? new_bits : open_bits;
    assign found = |cand;

    always_comb
    begin
        sel_v = '0;
        for (int v = EFF_V - 1; v >= 0; v--)
        begin
            if (cand[v])
            begin
                sel_v = VIDX_W'(v);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        marks_next     = marks_reg;
        depth_next     = depth_reg;
        n_next         = n_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        has_cycle_next = has_cycle_reg;
        push           = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_fire && q_item.last)
                begin
                    n_next     = n_active;
                    depth_next = '0;
                    for (int v = 0; v < EFF_V; v++)
                    begin
                        marks_next[v] = MARK_NEW;
                    end
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (depth_reg == '0)
                begin
                    if (found)
                    begin
                        marks_next[sel_v] = MARK_PATH;
                        depth_next        = DEPTH_W'(1);
                        push              = 1'b1;
                    end
                    else
                    begin
                        result_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                end
                else if (found)
                begin
                    if (marks_reg[sel_v] == MARK_PATH)
                    begin
                        // Back edge onto the current path: the graph has a cycle.
                        result_next = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        marks_next[sel_v] = MARK_PATH;
                        depth_next        = depth_reg + 1'b1;
                        push              = 1'b1;
                    end
                end
                else
                begin
                    marks_next[top_v] = MARK_DONE;
                    depth_next        = depth_m1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    has_cycle_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            n_reg         <= '0;
            result_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            has_cycle_reg <= 1'b0;
            for (int v = 0; v < EFF_V; v++)
            begin
                marks_reg[v] <= MARK_NEW;
            end
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            n_reg         <= n_next;
            result_reg    <= result_next;
            out_valid_reg <= out_valid_next;
            has_cycle_reg <= has_cycle_next;
            marks_reg     <= marks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_fire && q_item.store)
        begin
            rows_mem[q_item.row_index[VIDX_W-1:0]] <= q_item.row_bits[EFF_V-1:0];
        end
        if (push)
        begin
            stack_mem[depth_reg[VIDX_W-1:0]] <= sel_v;
        end
    end

    a_depth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (depth_reg <= DEPTH_W'(n_reg)))
        else $error("search stack deeper than the vertex count");

    a_top_on_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && depth_reg != '0) |-> (marks_reg[top_v] == MARK_PATH))
        else $error("stack top is not marked on path");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish state");

endmodule

`default_nettype wire

// ===== src/directed_cycle_detector_core.sv =====
// Flow: an accepted row transaction is written into the queue, and from there
//   into the row store when the search engine is idle. A transaction with tlast
//   set starts a search over n, the active vertex count (one stack push or pop per cycle).
// Throughput: one row per cycle while no search runs or waits on its result; the
//   search engine takes one transaction at a time, so a search holds back later rows.
// Reset: rst_n clears the queue, the search control and the output; the
//   vertex count returns to 16 and the row store is undefined until written.
// ----------------------------------------------------------------------------
// directed_cycle_detector_core: cycle detection on a directed graph
// Loads adjacency-matrix rows over a stream and answers, per graph, whether
// the graph contains a directed cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module directed_cycle_detector_core #(
    parameter int MAX_VERTICES = dcd_pkg::DEFAULT_MAX_VERTICES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // Configuration write channel: the vertex count register.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dcd_pkg::VCOUNT_W-1:0]    cfg_data,

    // Row input stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: row_index [3:0], row_bits [19:4], zero padding [23:20]
    input  wire logic [dcd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tlast,

    // Result stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: has_cycle [0], zero padding [7:1]
    output logic [dcd_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import dcd_pkg::*;

    // The vertex count register. Writes must be made only while the block is idle
    // (the block itself does not enforce this); the search engine samples it once when a search starts.
    logic [VCOUNT_W-1:0] vertex_count_reg;

    dcd_item_t q_item;
    logic      q_valid;
    logic      q_ready;
    logic      has_cycle;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

    // The front end takes each row transaction, marks whether its row fits
    // the store, and queues it. The queue lets rows of the next graph
    // arrive while a search or an unread result is pending.
    dcd_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .row_index (s_axis_tdata[IDX_W-1:0]),
        .row_bits  (s_axis_tdata[IDX_W+ROW_W-1:IDX_W]),
        .last_row  (s_axis_tlast),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    // The search engine writes rows into its store in order and, on a
    // transaction marked last, runs the depth-first search. Its result
    // sits in an output register, so a stalled consumer only blocks the
    // engine when the next search ends.
    dcd_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_count (vertex_count_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .has_cycle    (has_cycle)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - 1){1'b0}}, has_cycle};

endmodule

`default_nettype wire

// ===== dv/directed_cycle_detector_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directed_cycle_detector_core_test: self-checking bench for the cycle detector
// Loads adjacency rows over the input stream, triggers a search with tlast and
// checks each has_cycle answer against a local depth-first search predictor.
// A short directed table comes first. Random graphs follow: acyclic graphs,
// graphs with one back edge, sparse rewrites and broken row sequences. The
// vertex count changes between phases. Both streams idle at random.
// ----------------------------------------------------------------------------

module directed_cycle_detector_core_test;

    import dcd_pkg::*;

    localparam int NUM_VERTICES  = DEFAULT_MAX_VERTICES;
    localparam int TARGET_ROWS   = 800;
    localparam int HOLD_CYCLES   = 400;
    // Idle time after the last answer, so that a full search and any late rows can finish.
    localparam int SETTLE_CYCLES = 2 * NUM_VERTICES + 12;
    localparam int LIMIT_CYCLES  = 300000;

    typedef enum logic [1:0] {
        MARK_UNSEEN,
        MARK_ON_PATH,
        MARK_DONE
    } vertex_mark_e;

    typedef enum int {
        SHAPE_ACYCLIC,
        SHAPE_BACK_EDGE,
        SHAPE_SPARSE,
        SHAPE_NOISE
    } graph_shape_e;

    // One row of the directed table. A set_count row first rewrites the vertex
    // count while the block is idle. known marks a typed-in has_cycle value.
    typedef struct packed {
        logic                set_count;
        logic [VCOUNT_W-1:0] count_value;
        logic [IDX_W-1:0]    row_index;
        logic [ROW_W-1:0]    row_bits;
        logic                last_row;
        logic                known;
        logic                has_cycle;
    } directed_step_t;

    localparam int DIRECTED_STEPS = 26;
    localparam directed_step_t DIRECTED_TABLE [DIRECTED_STEPS] = '{
        // A chain 0 -> 1 -> ... -> 15 fills every row.
        '{1'b0, 5'd0,  4'd0,  16'h0002, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd1,  16'h0004, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd2,  16'h0008, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd3,  16'h0010, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd4,  16'h0020, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd5,  16'h0040, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd6,  16'h0080, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd7,  16'h0100, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd8,  16'h0200, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd9,  16'h0400, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd10, 16'h0800, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd11, 16'h1000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd12, 16'h2000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd13, 16'h4000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd14, 16'h8000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd15, 16'h0000, 1'b1, 1'b1, 1'b0},  // open chain
        '{1'b0, 5'd0,  4'd15, 16'h0001, 1'b1, 1'b1, 1'b1},  // ring over all 16
        '{1'b0, 5'd0,  4'd15, 16'h8000, 1'b1, 1'b1, 1'b1},  // self loop on 15
        '{1'b0, 5'd0,  4'd0,  16'hFFFF, 1'b1, 1'b1, 1'b1},  // self loop on 0
        '{1'b0, 5'd0,  4'd15, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 5'd0,  4'd0,  16'hFFFE, 1'b1, 1'b0, 1'b0},
        '{1'b1, 5'd0,  4'd0,  16'h0001, 1'b1, 1'b1, 1'b0},  // empty graph
        '{1'b1, 5'd31, 4'd3,  16'h5A5A, 1'b1, 1'b0, 1'b0},  // count saturates
        '{1'b1, 5'd1,  4'd0,  16'hFFFE, 1'b1, 1'b1, 1'b0},  // edges off graph
        '{1'b0, 5'd0,  4'd0,  16'h0001, 1'b1, 1'b1, 1'b1},
        '{1'b1, 5'd16, 4'd9,  16'h0200, 1'b1, 1'b1, 1'b1}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [VCOUNT_W-1:0]   cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Travel with each row so the monitor sees the typed answer of that row.
    logic                  row_typed_known;
    logic                  row_typed_cycle;

    // Predictor state: row store and vertex count as the block should hold them.
    logic [ROW_W-1:0]      graph_rows [NUM_VERTICES];
    logic [VCOUNT_W-1:0]   graph_vcount;
    logic                  cycle_answers [$];

    int errors;
    int cycle_count;
    int rows_accepted;
    int searches_checked;
    int cycles_found;
    int count_writes;
    int hold_requests;

    // Sender side bookkeeping.
    int  rows_sent;
    int  tx_burst_left;
    bit  tx_offering;
    int  drv_active_n;

    directed_cycle_detector_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Depth-first search with an explicit stack over the active vertices.
    // Any edge from the stack top to a vertex still on the path closes a cycle.
    function automatic logic graph_has_cycle();
        int           n;
        int           depth;
        int           top;
        bit           pushed;
        logic [15:0]  col_mask;
        logic [15:0]  edges;
        vertex_mark_e mark [NUM_VERTICES];
        logic [3:0]   path [NUM_VERTICES];
        n = (int'(graph_vcount) > NUM_VERTICES) ? NUM_VERTICES : int'(graph_vcount);
        col_mask = (n >= 16) ? 16'hFFFF : ((16'd1 << n) - 16'd1);
        foreach (mark[i])
            mark[i] = MARK_UNSEEN;
        for (int r = 0; r < n; r++)
        begin
            if (mark[r] != MARK_UNSEEN)
                continue;
            mark[r] = MARK_ON_PATH;
            path[0] = 4'(r);
            depth = 1;
            while (depth > 0)
            begin
                top = int'(path[depth - 1]);
                edges = graph_rows[top] & col_mask;
                pushed = 1'b0;
                for (int w = 0; w < n && !pushed; w++)
                begin
                    if (edges[w])
                    begin
                        if (mark[w] == MARK_ON_PATH)
                            return 1'b1;
                        if (mark[w] == MARK_UNSEEN)
                        begin
                            mark[w] = MARK_ON_PATH;
                            path[depth] = 4'(w);
                            depth++;
                            pushed = 1'b1;
                        end
                    end
                end
                if (!pushed)
                begin
                    mark[top] = MARK_DONE;
                    depth--;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void shuffle_vertices(output int order [NUM_VERTICES], input int n);
        int j;
        int swap;
        for (int i = 0; i < NUM_VERTICES; i++)
            order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
    endfunction

    function automatic logic [VCOUNT_W-1:0] pick_vertex_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return VCOUNT_W'($urandom_range(17, 31));
        else if (r == 2)
            return VCOUNT_W'(NUM_VERTICES);
        else if (r == 3)
            return VCOUNT_W'(1);
        return VCOUNT_W'($urandom_range(2, 16));
    endfunction

    // Offers one row transaction, idling between bursts, and returns at the
    // edge that accepts it.
    task automatic send_row(input logic [IDX_W-1:0] index, input logic [ROW_W-1:0] bits,
                            input logic last, input logic known, input logic typed);
        int gap;
        if (tx_burst_left == 0)
        begin
            tx_burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                        : $urandom_range(1, 12);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            if (tx_offering)
                s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tx_burst_left--;
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= {{(IN_DATA_W - IDX_W - ROW_W){1'b0}}, bits, index};
        s_axis_tlast    <= last;
        row_typed_known <= known;
        row_typed_cycle <= typed;
        tx_offering = 1'b1;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        rows_sent++;
    endtask

    // Stops offering rows until every pending answer has come back and the
    // block has had time to store any trailing rows. The first edge lets the
    // monitor record the answer of a row accepted just before.
    task automatic drain_results();
        if (tx_offering)
            s_axis_tvalid <= 1'b0;
        tx_offering = 1'b0;
        @(posedge clk);
        while (cycle_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        drv_active_n = (int'(value) > NUM_VERTICES) ? NUM_VERTICES : int'(value);
    endtask

    task automatic send_random_graph();
        int           n;
        int           rows_in_noise;
        int           a;
        int           b;
        int           order [NUM_VERTICES];
        int           send_order [NUM_VERTICES];
        logic [15:0]  live_mask;
        logic [15:0]  plan [NUM_VERTICES];
        graph_shape_e shape;
        n = drv_active_n;
        a = $urandom_range(0, 19);
        shape = (a < 7) ? SHAPE_ACYCLIC : (a < 13) ? SHAPE_BACK_EDGE :
                (a < 17) ? SHAPE_SPARSE : SHAPE_NOISE;
        if (n == 0 || shape == SHAPE_NOISE)
        begin
            // Broken sequence: stray rows with searches started at random.
            rows_in_noise = $urandom_range(1, 8);
            for (int k = 0; k < rows_in_noise; k++)
                send_row(IDX_W'($urandom_range(0, 15)), ROW_W'($urandom),
                         (k == rows_in_noise - 1) || ($urandom_range(0, 3) == 0), 1'b0, 1'b0);
            return;
        end
        live_mask = (n >= 16) ? 16'hFFFF : ((16'd1 << n) - 16'd1);
        shuffle_vertices(order, n);
        shuffle_vertices(send_order, n);
        // Columns beyond the vertex count carry junk that the search must ignore.
        for (int i = 0; i < NUM_VERTICES; i++)
            plan[i] = ($urandom_range(0, 1) == 0) ? 16'h0000 : (16'($urandom) & ~live_mask);
        if (shape == SHAPE_SPARSE)
        begin
            for (int i = 0; i < n; i++)
                plan[i] |= ($urandom_range(0, 1) == 0) ? (16'($urandom & $urandom & $urandom))
                                                       : (16'($urandom & $urandom));
        end
        else
        begin
            // Edges only run forward in a random topological order.
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if ($urandom_range(0, 2) == 0)
                        plan[order[i]][order[j]] = 1'b1;
            if (shape == SHAPE_BACK_EDGE)
            begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(a, n - 1);
                plan[order[b]][order[a]] = 1'b1;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            if (shape == SHAPE_SPARSE && k != n - 1 && $urandom_range(0, 2) == 0)
                continue;
            if (shape == SHAPE_SPARSE && n < NUM_VERTICES && $urandom_range(0, 4) == 0)
            begin
                a = $urandom_range(n, NUM_VERTICES - 1);
                send_row(IDX_W'(a), ROW_W'($urandom), 1'b0, 1'b0, 1'b0);
            end
            send_row(IDX_W'(send_order[k]), plan[send_order[k]], k == n - 1, 1'b0, 1'b0);
        end
    endtask

    // Receiver: alternating ready and stall runs, plus long hold-offs on request.
    initial
    begin
        int run_left;
        int hold_left;
        int holds_served;
        bit run_ready;
        run_left = 0;
        hold_left = 0;
        holds_served = 0;
        run_ready = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_ready = !run_ready;
                    if (run_ready)
                        run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                               : $urandom_range(1, 10);
                    else
                        run_left = $urandom_range(1, 6);
                end
                run_left--;
                m_axis_tready <= run_ready;
            end
        end
    end

    // Monitor: tracks configuration and rows, predicts on tlast, checks answers.
    always @(posedge clk)
    begin
        logic expected;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d answers pending.",
                     cycle_count, cycle_answers.size());
            $display("*** FAILED ***");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                graph_vcount = cfg_data;
                count_writes++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                graph_rows[s_axis_tdata[IDX_W-1:0]] = s_axis_tdata[IDX_W +: ROW_W];
                rows_accepted++;
                if (s_axis_tlast)
                begin
                    expected = graph_has_cycle();
                    if (row_typed_known)
                        expected = row_typed_cycle;
                    cycle_answers.push_back(expected);
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cycle_answers.size() == 0)
                begin
                    $error("unexpected result transaction, has_cycle actual %0b",
                           m_axis_tdata[0]);
                    errors++;
                end
                else
                begin
                    expected = cycle_answers.pop_front();
                    searches_checked++;
                    if (expected)
                        cycles_found++;
                    if (m_axis_tdata[0] !== expected)
                    begin
                        $error("has_cycle mismatch: expected %0b, actual %0b",
                               expected, m_axis_tdata[0]);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int graph_no;
        directed_step_t step;
        errors = 0;
        cycle_count = 0;
        rows_accepted = 0;
        searches_checked = 0;
        cycles_found = 0;
        count_writes = 0;
        hold_requests = 0;
        rows_sent = 0;
        tx_burst_left = 0;
        tx_offering = 1'b0;
        drv_active_n = NUM_VERTICES;
        graph_vcount = VCOUNT_RESET;
        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_data        <= '0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        s_axis_tlast    <= 1'b0;
        row_typed_known <= 1'b0;
        row_typed_cycle <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int s = 0; s < DIRECTED_STEPS; s++)
        begin
            step = DIRECTED_TABLE[s];
            if (step.set_count)
            begin
                drain_results();
                write_vertex_count(step.count_value);
            end
            send_row(step.row_index, step.row_bits, step.last_row, step.known, step.has_cycle);
        end

        graph_no = 0;
        while (rows_sent < TARGET_ROWS)
        begin
            // Long receiver hold-off while rows keep coming: the block backs up.
            if (graph_no % 25 == 7)
                hold_requests++;
            if (graph_no % 20 == 13)
                drain_results();
            if ($urandom_range(0, 3) == 0)
            begin
                drain_results();
                write_vertex_count(pick_vertex_count());
            end
            send_random_graph();
            graph_no++;
        end

        drain_results();
        if (cycle_answers.size() != 0)
        begin
            $error("%0d expected answers never arrived", cycle_answers.size());
            errors++;
        end
        $display("Covered %0d row transactions and %0d searches, %0d of them with a cycle.",
                 rows_accepted, searches_checked, cycles_found);
        $display("Vertex count rewritten %0d times, empty and saturated settings included.",
                 count_writes);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
